// ===== hdl/edonkey_udp_flow_classifier_core_defines.svh =====
// Assertion helpers for the flow classifier.
// Each expects clk and arst_n in scope.
`ifndef EDONKEY_UDP_FLOW_CLASSIFIER_CORE_DEFINES_SVH
`define EDONKEY_UDP_FLOW_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define EFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/efc_pkg.sv =====
package efc_pkg;

	// verdict codes
	localparam logic [1:0] VERDICT_NONE     = 2'd0;
	localparam logic [1:0] VERDICT_DETECTED = 2'd1;
	localparam logic [1:0] VERDICT_WAIT     = 2'd2;

	// config register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_PORTS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_LIMIT = 2'd2;
	localparam int unsigned CFG_DATA_W = 4;

	localparam logic       RST_UPPER_PORTS  = 1'b0;
	localparam logic [3:0] RST_THRESHOLD    = 4'd6;
	localparam logic [3:0] RST_PACKET_LIMIT = 4'd10;

	typedef struct packed {
		logic [3:0] score;
		logic       excluded;
		logic [3:0] count;
	} flow_entry_t;

	localparam int unsigned ENTRY_W = $bits(flow_entry_t);

	typedef struct packed {
		logic       upper_ports_only;
		logic [3:0] score_threshold;
		logic [3:0] packet_limit;
	} cfg_t;

	typedef struct packed {
		logic        flow_start;
		logic [15:0] payload_len;
		logic [7:0]  head_byte0;
		logic [7:0]  head_byte1;
		logic [7:0]  head_byte2;
		logic [7:0]  head_byte3;
		logic [7:0]  entry_count_byte;
		logic        port_known_hit;
		logic        other_proto_seen;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} item_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [3:0] score;
	} result_t;

endpackage

// ===== hdl/efc_ram.sv =====
module efc_ram #(
	parameter int unsigned WIDTH = 9,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [WIDTH-1:0]     rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== hdl/efc_rules.sv =====
// Per-packet decision on one flow entry: returns the updated entry and verdict.
module efc_rules
	import efc_pkg::*;
(
	input  item_t       item,
	input  flow_entry_t entry_in,
	input  cfg_t        cfg,
	output flow_entry_t entry_out,
	output result_t     res
);
	localparam logic [7:0] MARK_KAD   = 8'he4;
	localparam logic [7:0] MARK_EDK   = 8'he3;
	localparam logic [7:0] MARK_EMULE = 8'hc5;
	localparam logic [7:0] MARK_PACK  = 8'he5;

	flow_entry_t e0;
	logic [3:0]  cnt1;
	logic        sport_bad, dport_bad;
	logic        len_ge19, kad;
	logic [15:0] list_len;
	logic [1:0]  gain;
	logic [4:0]  sum;
	logic [3:0]  score_new;
	logic        sig6;
	logic [7:0]  b0, b1, b2, b3;

	assign b0 = item.head_byte0;
	assign b1 = item.head_byte1;
	assign b2 = item.head_byte2;
	assign b3 = item.head_byte3;

	function automatic logic port_bad(input logic [15:0] p);
		return (p < 16'd1024) && (p != 16'd80) && (p != 16'd443);
	endfunction

	always_comb begin
		e0 = item.flow_start ? '0 : entry_in;
		cnt1 = ((item.payload_len != 16'd0) && (e0.count != 4'hf)) ? e0.count + 4'd1
			: e0.count;
		sport_bad = port_bad(item.source_port);
		dport_bad = port_bad(item.dest_port);
	end

	// score gain for 0xe4 packets
	always_comb begin
		len_ge19 = item.payload_len >= 16'd19;
		kad = len_ge19 && (b0 == MARK_KAD);
		// 19 + 25 * byte18
		list_len = 16'({item.entry_count_byte, 4'b0000}) + 16'({item.entry_count_byte, 3'b000})
			+ 16'(item.entry_count_byte) + 16'd19;
		gain = 2'd0;
		if (kad) begin
			if (item.payload_len == 16'd35 && (b1 == 8'h21 || b1 == 8'h20)) begin
				gain = 2'd2;
			end else if (item.payload_len == 16'd19
				&& (b1 == 8'h4b || b1 == 8'h48 || b1 == 8'h30)) begin
				gain = 2'd2;
			end else if (item.payload_len == 16'd27 && (b1 == 8'h10 || b1 == 8'h18)) begin
				gain = 2'd2;
			end else if ((b1 == 8'h29 || b1 == 8'h28) && item.payload_len == list_len) begin
				gain = 2'd1;
			end else if (item.payload_len > 16'd19 && (b1 == 8'h43 || b1 == 8'h38)) begin
				gain = 2'd1;
			end else if (item.payload_len > 16'd22 && (b1 == 8'h11 || b1 == 8'h19)) begin
				gain = 2'd1;
			end
		end
		sum = {1'b0, e0.score} + {3'b000, gain};
		score_new = sum[4] ? 4'hf : sum[3:0];
	end

	// six-byte signature list
	always_comb begin
		sig6 = 1'b0;
		if ((b0 == MARK_EDK || b0 == MARK_EMULE) && b2 == 8'h00 && b3 == 8'h00) begin
			sig6 = 1'b1;
		end else if (b0 == MARK_PACK) begin
			sig6 = (b1 == 8'h43) || ((b1 == 8'h08 || b1 == 8'h28) && b2 == 8'h78 && b3 == 8'hda);
		end else if (b0 == MARK_EMULE) begin
			sig6 = (b1 == 8'h90) || (b1 == 8'h91);
		end else if (b0 == MARK_EDK) begin
			sig6 = b1 == 8'h9a || b1 == 8'h9b || b1 == 8'h96 || b1 == 8'h97 || b1 == 8'h92
				|| b1 == 8'h94 || b1 == 8'h98 || b1 == 8'h99 || b1 == 8'ha2 || b1 == 8'ha3;
		end else if (b0 == MARK_KAD) begin
			sig6 = (b1 == 8'h11) || (b1 == 8'h58);
		end
	end

	always_comb begin
		entry_out = e0;
		entry_out.count = cnt1;
		res.score = e0.score;
		res.verdict = VERDICT_WAIT;
		if (e0.excluded) begin
			res.verdict = VERDICT_NONE;
		end else if (cfg.upper_ports_only && (sport_bad || dport_bad)) begin
			entry_out.excluded = 1'b1;
			res.verdict = VERDICT_NONE;
		end else if (item.payload_len == 16'd0) begin
			res.verdict = VERDICT_WAIT;
		end else if (e0.score == 4'd0 && item.other_proto_seen) begin
			res.verdict = VERDICT_WAIT;
		end else if (item.port_known_hit) begin
			res.verdict = VERDICT_DETECTED;
		end else begin
			entry_out.score = score_new;
			res.score = score_new;
			if (item.payload_len == 16'd6 && sig6) begin
				res.verdict = VERDICT_DETECTED;
			end else if (score_new >= cfg.score_threshold) begin
				res.verdict = VERDICT_DETECTED;
			end else if (cnt1 > cfg.packet_limit) begin
				entry_out.excluded = 1'b1;
				res.verdict = VERDICT_NONE;
			end else begin
				res.verdict = VERDICT_WAIT;
			end
		end
	end
endmodule

// ===== hdl/edonkey_udp_flow_classifier_core.sv =====
// UDP flow classifier for eDonkey traffic. Each input word is one parsed packet
// header; each produces exactly one output word (verdict, score_now). Per-flow
// state (score, excluded mark, packet count) lives in one FLOW_SLOTS x 9 bit
// synchronous RAM; flow_slot is wrapped modulo FLOW_SLOTS. On accept a packet
// enters the stage-1 register and its RAM read is issued; its result goes into
// the output register, raising out_valid, when stage 1 advances. A new packet
// is accepted every cycle as long as the output side keeps up. That rate is set
// by the single RAM read-modify-write: the read is issued on accept, the update
// is computed and written back as the packet leaves stage 1, and a one-entry
// write-back register forwards that update to a following packet of the same
// flow. After reset the block sweeps all FLOW_SLOTS entries (1024 by default)
// of the RAM to zero, one entry per cycle, while in_stall is high; config writes
// are taken any time. Config writes belong only in idle periods.
module edonkey_udp_flow_classifier_core
	import efc_pkg::*;
#(
	parameter int unsigned FLOW_SLOTS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [9:0]           flow_slot,
	input  logic                 flow_start,
	input  logic [15:0]          payload_len,
	input  logic [7:0]           head_byte0,
	input  logic [7:0]           head_byte1,
	input  logic [7:0]           head_byte2,
	input  logic [7:0]           head_byte3,
	input  logic [7:0]           entry_count_byte,
	input  logic                 port_known_hit,
	input  logic                 other_proto_seen,
	input  logic [15:0]          source_port,
	input  logic [15:0]          dest_port,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           verdict,
	output logic [3:0]           score_now
);
	`include "edonkey_udp_flow_classifier_core_defines.svh"

	localparam int unsigned SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;

	// slot modulo table size: restoring reduction against shifted multiples
	// of a constant, only used when the table is shallower than the slot range
	function automatic logic [9:0] slot_wrap(input logic [9:0] x);
		logic [19:0] r;
		logic [19:0] d;
		r = {10'd0, x};
		for (int k = 9; k >= 0; k--) begin
			d = 20'(FLOW_SLOTS) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[9:0];
	endfunction

	// config registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper_ports_only <= RST_UPPER_PORTS;
			cfg_q.score_threshold  <= RST_THRESHOLD;
			cfg_q.packet_limit     <= RST_PACKET_LIMIT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_UPPER_PORTS:  cfg_q.upper_ports_only <= cfg_data[0];
				REG_THRESHOLD:    cfg_q.score_threshold  <= cfg_data[3:0];
				REG_PACKET_LIMIT: cfg_q.packet_limit     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clearing sweep after reset
	logic              clr_busy_q;
	logic [SLOT_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == SLOT_W'(FLOW_SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// handshake
	logic valid_s1;
	logic out_valid_q;
	logic in_accept;
	logic advance;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = clr_busy_q || (valid_s1 && out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;

	// slot address for the RAM read
	logic [SLOT_W-1:0] rd_slot;

	generate
		if (FLOW_SLOTS >= 1024) begin : g_slot_direct
			assign rd_slot = SLOT_W'(flow_slot);
		end else begin : g_slot_wrap
			logic [9:0] wrapped;
			assign wrapped = slot_wrap(flow_slot);
			assign rd_slot = wrapped[SLOT_W-1:0];
		end
	endgenerate

	// stage 1: item waits for its entry
	item_t             item_s1;
	logic [SLOT_W-1:0] slot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			slot_s1                   <= rd_slot;
			item_s1.flow_start        <= flow_start;
			item_s1.payload_len       <= payload_len;
			item_s1.head_byte0        <= head_byte0;
			item_s1.head_byte1        <= head_byte1;
			item_s1.head_byte2        <= head_byte2;
			item_s1.head_byte3        <= head_byte3;
			item_s1.entry_count_byte  <= entry_count_byte;
			item_s1.port_known_hit    <= port_known_hit;
			item_s1.other_proto_seen  <= other_proto_seen;
			item_s1.source_port       <= source_port;
			item_s1.dest_port         <= dest_port;
		end
	end

	// flow table
	logic                wr_en;
	logic [SLOT_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0]  wr_data;
	logic [ENTRY_W-1:0]  rd_data;
	flow_entry_t         entry_new;

	assign wr_en   = advance || clr_busy_q;
	assign wr_addr = clr_busy_q ? clr_idx_q : slot_s1;
	assign wr_data = clr_busy_q ? '0 : entry_new;

	efc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (FLOW_SLOTS)
	) u_flow_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (in_accept),
		.rd_addr (rd_slot),
		.rd_data (rd_data)
	);

	// last write-back; covers a read that raced the previous packet's write
	logic              wb_valid_q;
	logic [SLOT_W-1:0] wb_slot_q;
	flow_entry_t       wb_entry_q;
	flow_entry_t       entry_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_q <= 1'b0;
		end else if (advance) begin
			wb_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wb_slot_q  <= slot_s1;
			wb_entry_q <= entry_new;
		end
	end

	assign entry_cur = (wb_valid_q && wb_slot_q == slot_s1) ? wb_entry_q
		: flow_entry_t'(rd_data);

	result_t res;

	efc_rules u_rules (
		.item      (item_s1),
		.entry_in  (entry_cur),
		.cfg       (cfg_q),
		.entry_out (entry_new),
		.res       (res)
	);

	// output register
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = res_q.verdict;
	assign score_now = res_q.score;

	`EFC_ASSERT_NOW(a_clear_blocks_items, clr_busy_q, !valid_s1 && !in_accept,
		"packet in flight during table clear")
	`EFC_ASSERT_NOW(a_score_monotonic, advance && !item_s1.flow_start,
		entry_new.score >= entry_cur.score, "flow score went down")
	`EFC_ASSERT_NOW(a_excluded_not_detected, advance && entry_new.excluded,
		res.verdict != VERDICT_DETECTED, "excluded flow reported as detected")
	`EFC_ASSERT_NEXT(a_result_follows_accept, in_accept, valid_s1,
		"accepted packet did not enter stage 1")
endmodule
